>>> sv/binary_blit_raster_op_assert.svh
// Assertion helpers for the blitter, clocked on clk, off while in reset.
`ifndef BINARY_BLIT_RASTER_OP_ASSERT_SVH
`define BINARY_BLIT_RASTER_OP_ASSERT_SVH

// Same-cycle implication
`define BBRO_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define BBRO_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/bbro_pkg.sv
package bbro_pkg;

	// Default sizes of the layer canvas
	localparam int DEF_MAX_LAYER_WIDTH  = 256;
	localparam int DEF_MAX_LAYER_HEIGHT = 128;
	localparam int DEF_CANVAS_BITS      = 32768;

	// Field widths
	localparam int COORD_W   = 11;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 10;

	// Item commands
	typedef enum logic [1:0] {
		CMD_OBJ   = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// Combine modes
	typedef enum logic [1:0] {
		MODE_OR   = 2'd0,
		MODE_XOR  = 2'd1,
		MODE_COPY = 2'd2,
		MODE_INV  = 2'd3
	} mode_t;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LAYER_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAYER_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OBJ_POS_X    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OBJ_POS_Y    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OBJ_WIDTH    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_OBJ_HEIGHT   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RENDER_MODE  = 3'd6;

endpackage

>>> sv/binary_blit_raster_op.sv
// Channel   Dir  Handshake         Payload
// s_*       in   s_tvalid/s_tready tdata: pixel_in, pos_col, pos_row; tuser: cmd
// m_*       out  m_tvalid/m_tready tdata: pixel_out, out_col, out_row; tuser: written;
//                                  tlast: last
// cfg_*     in   cfg_wen           cfg_index, cfg_wdata
//
// One item per cycle while m_tready is high and no clearing pass runs; a request
// passes an address stage, a canvas read stage and an output register. The canvas
// is a one-port-write, one-port-read memory; a write back that meets the next read
// of the same bit is forwarded. After reset a clearing pass zeroes all CANVAS_BITS
// canvas bits with s_tready low. A low m_tready stalls the pipeline back to
// s_tready. A request with the unused command is taken and dropped.
`include "binary_blit_raster_op_assert.svh"

module binary_blit_raster_op import bbro_pkg::*; #(
	parameter int MAX_LAYER_WIDTH  = DEF_MAX_LAYER_WIDTH,
	parameter int MAX_LAYER_HEIGHT = DEF_MAX_LAYER_HEIGHT,
	parameter int CANVAS_BITS      = DEF_CANVAS_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // [0] pixel_in, [8:1] pos_col, [15:9] pos_row
	input  logic [1:0]           s_tuser,   // [1:0] cmd
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [23:0]          m_tdata,   // [0] pixel_out, [11:1] out_col, [22:12] out_row
	output logic [0:0]           m_tuser,   // [0] written
	output logic                 m_tlast,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_wdata
);

	localparam int ADDR_W = $clog2(CANVAS_BITS);
	localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(CANVAS_BITS - 1);

	// Configuration registers
	logic [8:0] layer_width_q;
	logic [7:0] layer_height_q;
	logic [9:0] obj_pos_x_q;
	logic [9:0] obj_pos_y_q;
	logic [9:0] obj_width_q;
	logic [9:0] obj_height_q;
	mode_t      render_mode_q;

	// Object counters and clearing pass
	logic [8:0]        obj_col_q;
	logic [8:0]        obj_row_q;
	logic              clr_active_q;
	logic [ADDR_W-1:0] clr_addr_q;

	// Canvas
	logic canvas_mem [CANVAS_BITS];

	// Stage 1
	logic                valid_s1;
	cmd_t                cmd_s1;
	logic                pix_s1;
	logic [COORD_W-1:0]  col_s1;
	logic [COORD_W-1:0]  row_s1;
	logic                last_s1;

	// Stage 2
	logic                valid_s2;
	cmd_t                cmd_s2;
	logic                pix_s2;
	logic [COORD_W-1:0]  col_s2;
	logic [COORD_W-1:0]  row_s2;
	logic                last_s2;
	logic                inside_s2;
	logic [ADDR_W-1:0]   addr_s2;
	logic                fwd_hit_s2;
	logic                fwd_pix_s2;
	logic                rd_s2;

	// Output register
	logic                out_valid_q;
	logic                out_pix_q;
	logic [COORD_W-1:0]  out_col_q;
	logic [COORD_W-1:0]  out_row_q;
	logic                out_wr_q;
	logic                out_last_q;

	// Combinational signals
	logic [10:0]        lw_eff;
	logic [10:0]        lh_eff;
	logic [9:0]         ow_eff;
	logic [9:0]         oh_eff;
	cmd_t               in_cmd;
	logic               in_accept;
	logic               in_enter;
	logic [COORD_W-1:0] in_col;
	logic [COORD_W-1:0] in_row;
	logic               row_wrap;
	logic               col_wrap;
	logic [16:0]        prod_s1;
	logic [16:0]        idx_s1;
	logic               inside_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic               cur_s2;
	logic               nv_s2;
	logic               we_s2;
	logic               pout_s2;
	logic               s2_adv;
	logic               s2_free;
	logic               s1_adv;
	logic               s1_free;
	logic               mem_we;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_width_q  <= 9'd256;
			layer_height_q <= 8'd128;
			obj_pos_x_q    <= 10'd0;
			obj_pos_y_q    <= 10'd0;
			obj_width_q    <= 10'd1;
			obj_height_q   <= 10'd1;
			render_mode_q  <= MODE_OR;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_LAYER_WIDTH:  layer_width_q  <= cfg_wdata[8:0];
				CFG_LAYER_HEIGHT: layer_height_q <= cfg_wdata[7:0];
				CFG_OBJ_POS_X:    obj_pos_x_q    <= cfg_wdata;
				CFG_OBJ_POS_Y:    obj_pos_y_q    <= cfg_wdata;
				CFG_OBJ_WIDTH:    obj_width_q    <= cfg_wdata;
				CFG_OBJ_HEIGHT:   obj_height_q   <= cfg_wdata;
				CFG_RENDER_MODE:  render_mode_q  <= mode_t'(cfg_wdata[1:0]);
				default: ;
			endcase
		end
	end

	// Saturate layer and object sizes to their maxima; a zero object size counts as one
	always_comb begin
		lw_eff = ({2'b00, layer_width_q} > 11'(MAX_LAYER_WIDTH)) ?
			11'(MAX_LAYER_WIDTH) : {2'b00, layer_width_q};
		lh_eff = ({3'b000, layer_height_q} > 11'(MAX_LAYER_HEIGHT)) ?
			11'(MAX_LAYER_HEIGHT) : {3'b000, layer_height_q};
		if (obj_width_q == 10'd0)
			ow_eff = 10'd1;
		else if (obj_width_q > 10'd512)
			ow_eff = 10'd512;
		else
			ow_eff = obj_width_q;
		if (obj_height_q == 10'd0)
			oh_eff = 10'd1;
		else if (obj_height_q > 10'd512)
			oh_eff = 10'd512;
		else
			oh_eff = obj_height_q;
	end

	// Handshake chain
	always_comb begin
		s2_adv    = valid_s2 && (!out_valid_q || m_tready);
		s2_free   = !valid_s2 || s2_adv;
		s1_adv    = valid_s1 && s2_free;
		s1_free   = !valid_s1 || s1_adv;
		s_tready  = !clr_active_q && s1_free;
		in_accept = s_tvalid && s_tready;
		in_cmd    = cmd_t'(s_tuser);
		in_enter  = in_accept && (in_cmd != CMD_NONE);
	end

	// Form the layer location of the request
	always_comb begin
		row_wrap = ({1'b0, obj_row_q} + 10'd1) >= oh_eff;
		col_wrap = ({1'b0, obj_col_q} + 10'd1) >= ow_eff;
		if (in_cmd == CMD_OBJ) begin
			in_col = {obj_pos_x_q[9], obj_pos_x_q} + {2'b00, obj_col_q};
			in_row = {obj_pos_y_q[9], obj_pos_y_q} + {2'b00, obj_row_q};
		end else begin
			in_col = {3'b000, s_tdata[8:1]};
			in_row = {4'b0000, s_tdata[15:9]};
		end
	end

	// Advance object counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_col_q <= 9'd0;
			obj_row_q <= 9'd0;
		end else if (in_accept && in_cmd == CMD_OBJ) begin
			if (row_wrap) begin
				obj_row_q <= 9'd0;
				obj_col_q <= col_wrap ? 9'd0 : obj_col_q + 9'd1;
			end else begin
				obj_row_q <= obj_row_q + 9'd1;
			end
		end
	end

	// Sweep the canvas to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (clr_addr_q == CLR_LAST)
				clr_active_q <= 1'b0;
		end
	end

	// Stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s1_free)
			valid_s1 <= in_enter;
	end

	always_ff @(posedge clk) begin
		if (s1_free && in_enter) begin
			cmd_s1  <= in_cmd;
			pix_s1  <= s_tdata[0];
			col_s1  <= in_col;
			row_s1  <= in_row;
			last_s1 <= (in_cmd == CMD_OBJ) && row_wrap && col_wrap;
		end
	end

	// Clip and form the bit address
	always_comb begin
		prod_s1   = 17'(col_s1[8:0]) * 17'(lh_eff[7:0]);
		idx_s1    = prod_s1 + 17'(row_s1[7:0]);
		inside_s1 = !col_s1[10] && !row_s1[10] && (col_s1 < lw_eff) && (row_s1 < lh_eff)
			&& (32'(idx_s1) < 32'(CANVAS_BITS));
		addr_s1   = ADDR_W'(idx_s1);
	end

	// Stage 2 registers, with forward of a write back to the same bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (s2_free)
			valid_s2 <= s1_adv;
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			cmd_s2     <= cmd_s1;
			pix_s2     <= pix_s1;
			col_s2     <= col_s1;
			row_s2     <= row_s1;
			last_s2    <= last_s1;
			inside_s2  <= inside_s1;
			addr_s2    <= addr_s1;
			fwd_hit_s2 <= mem_we && (addr_s2 == addr_s1);
			fwd_pix_s2 <= nv_s2;
		end
	end

	// Combine the pixel with the canvas
	always_comb begin
		cur_s2 = fwd_hit_s2 ? fwd_pix_s2 : rd_s2;
		case (cmd_s2)
			CMD_OBJ: begin
				case (render_mode_q)
					MODE_OR:   nv_s2 = cur_s2 | pix_s2;
					MODE_XOR:  nv_s2 = cur_s2 ^ pix_s2;
					MODE_COPY: nv_s2 = pix_s2;
					MODE_INV:  nv_s2 = !pix_s2;
					default:   nv_s2 = pix_s2;
				endcase
			end
			CMD_WRITE: nv_s2 = pix_s2;
			default:   nv_s2 = cur_s2;
		endcase
		we_s2   = inside_s2 && (cmd_s2 != CMD_READ);
		pout_s2 = inside_s2 && nv_s2;
		mem_we  = s2_adv && we_s2;
	end

	// Canvas memory: clear sweep or write back, registered read
	always_ff @(posedge clk) begin
		if (clr_active_q)
			canvas_mem[clr_addr_q] <= 1'b0;
		else if (mem_we)
			canvas_mem[addr_s2] <= nv_s2;
		if (s1_adv)
			rd_s2 <= canvas_mem[addr_s1];
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s2_adv)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			out_pix_q  <= pout_s2;
			out_col_q  <= col_s2;
			out_row_q  <= row_s2;
			out_wr_q   <= we_s2;
			out_last_q <= last_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_row_q, out_col_q, out_pix_q};
	assign m_tuser  = out_wr_q;
	assign m_tlast  = out_last_q;

	`BBRO_ASSERT_NOW(a_no_req_in_clear, clr_active_q, !s_tready && !mem_we,
		"request or write back during canvas clear")
	`BBRO_ASSERT_NOW(a_written_inside, m_tvalid && m_tuser[0],
		!out_col_q[10] && !out_row_q[10], "write reported outside the layer")
	`BBRO_ASSERT_NEXT(a_clear_ends, clr_active_q && (clr_addr_q == CLR_LAST),
		!clr_active_q && !valid_s1, "clear pass did not end at the last address")

endmodule
